// ===== sv/keyboard_mouse_packet_parser_top_macros.svh =====
// Assertion macros for the keyboard/mouse packet parser checker.
// No dependencies; included by the checker file.
`ifndef KEYBOARD_MOUSE_PACKET_PARSER_TOP_MACROS_SVH
`define KEYBOARD_MOUSE_PACKET_PARSER_TOP_MACROS_SVH

// Clocked on clk, masked while rst is high.
`define KMPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked on clk, also checked through reset.
`define KMPP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/kmpp_pkg.sv =====
// Shared types and constants for the keyboard/mouse packet parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package kmpp_pkg;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_BYTE    = 2'd0;
  localparam logic [1:0] REQ_OVERRUN = 2'd1;
  localparam logic [1:0] REQ_RECOVER = 2'd2;

  // Header bytes seen in key mode
  localparam logic [7:0] HDR_NOP      = 8'hF1;
  localparam logic [7:0] HDR_ABS      = 8'hF7;
  localparam logic [7:0] HDR_REL      = 8'hF8;
  localparam logic [7:0] HDR_CLOCK    = 8'hFC;
  localparam logic [7:0] HDR_JOY      = 8'hFE;
  localparam logic [7:0] KEY_IDX_MASK = 8'h7F;
  localparam logic [7:0] KEY_BREAK    = 8'h80;

  // Packet lengths after the header
  localparam logic [2:0] LEN_ONE   = 3'd1;
  localparam logic [2:0] LEN_REL   = 3'd2;
  localparam logic [2:0] LEN_ABS   = 3'd5;
  localparam logic [2:0] LEN_CLOCK = 3'd6;

  localparam int         PKT_DEPTH      = 5;
  localparam logic [7:0] RECOVER_BUTTONS = 8'h0A;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic               fault;
    logic               key_valid;
    logic [6:0]         key_index;
    logic               key_down;
    logic               key_changed;
    logic               mouse_valid;
    logic [7:0]         mouse_buttons;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/kmpp_engine.sv =====
// Parser state and per-byte next-state logic: mode, packet buffer, mouse, key map.
// Depends on kmpp_pkg.
`default_nettype none

module kmpp_engine (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic             parser_enable,
  input  wire kmpp_pkg::item_t  item,
  output kmpp_pkg::result_t     result
);
  import kmpp_pkg::*;

  typedef enum logic [2:0] {
    MODE_KEY, MODE_FAULT, MODE_ABS, MODE_REL, MODE_JOY, MODE_CLOCK
  } mode_t;

  mode_t        mode, mode_next;
  logic [2:0]   remaining, remaining_next;
  logic [2:0]   fill, fill_next;
  logic [7:0]   pkt [PKT_DEPTH];
  logic [7:0]   pkt_next [PKT_DEPTH];
  logic [15:0]  pos_x, pos_x_next;
  logic [15:0]  pos_y, pos_y_next;
  logic [7:0]   buttons, buttons_next;
  logic [127:0] key_map;
  logic         keys_clear;
  logic         key_valid, key_down, key_changed, mouse_valid;
  logic [6:0]   key_index;
  logic         go;

  assign go = step && parser_enable;

  always_comb begin
    logic [7:0] b;
    logic       done;
    b              = item.rx_byte;
    done           = 1'b0;
    mode_next      = mode;
    remaining_next = remaining;
    fill_next      = fill;
    pkt_next       = pkt;
    pos_x_next     = pos_x;
    pos_y_next     = pos_y;
    buttons_next   = buttons;
    keys_clear     = 1'b0;
    key_valid      = 1'b0;
    key_index      = '0;
    key_down       = 1'b0;
    key_changed    = 1'b0;
    mouse_valid    = 1'b0;
    if (go) begin
      case (item.req_type)
        REQ_OVERRUN: begin
          // drop any partial packet
          mode_next      = MODE_FAULT;
          fill_next      = '0;
          remaining_next = LEN_ONE;
        end
        REQ_RECOVER: begin
          if (mode == MODE_FAULT) begin
            keys_clear     = 1'b1;
            buttons_next   = RECOVER_BUTTONS;
            mode_next      = MODE_KEY;
            fill_next      = '0;
            remaining_next = LEN_ONE;
            mouse_valid    = 1'b1;
          end
        end
        REQ_BYTE: begin
          if (mode != MODE_FAULT) begin
            done = (remaining <= LEN_ONE);
            if (fill < 3'(PKT_DEPTH)) begin
              pkt_next[fill] = b;
            end
            fill_next = fill + 3'd1;
            if (!done) begin
              remaining_next = remaining - 3'd1;
            end else begin
              mode_next      = MODE_KEY;
              fill_next      = '0;
              remaining_next = LEN_ONE;
              case (mode)
                MODE_KEY: begin
                  if (b == HDR_NOP) begin
                    mode_next = MODE_KEY;
                  end else if (b == HDR_ABS) begin
                    mode_next      = MODE_ABS;
                    remaining_next = LEN_ABS;
                  end else if (b >= HDR_REL && b < HDR_CLOCK) begin
                    // header carries the buttons
                    mode_next      = MODE_REL;
                    remaining_next = LEN_REL;
                    pkt_next[0]    = b & 8'h03;
                    fill_next      = 3'd1;
                  end else if (b == HDR_CLOCK) begin
                    mode_next      = MODE_CLOCK;
                    remaining_next = LEN_CLOCK;
                  end else if (b >= HDR_JOY) begin
                    mode_next   = MODE_JOY;
                    pkt_next[0] = b & 8'h01;
                    fill_next   = 3'd1;
                  end else begin
                    key_valid   = 1'b1;
                    key_index   = 7'(b & KEY_IDX_MASK);
                    key_down    = ((b & KEY_BREAK) == 8'h00);
                    key_changed = (key_map[key_index] != key_down);
                  end
                end
                MODE_ABS: begin
                  buttons_next = pkt_next[0];
                  pos_x_next   = {pkt_next[1], pkt_next[2]};
                  pos_y_next   = {pkt_next[3], pkt_next[4]};
                  mouse_valid  = 1'b1;
                end
                MODE_REL: begin
                  buttons_next = pkt_next[0];
                  pos_x_next   = pos_x + {{8{pkt_next[1][7]}}, pkt_next[1]};
                  pos_y_next   = pos_y + {{8{pkt_next[2][7]}}, pkt_next[2]};
                  mouse_valid  = 1'b1;
                end
                default: begin
                  mode_next = MODE_KEY;
                end
              endcase
            end
          end
        end
        default: begin
          mode_next = mode;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_KEY;
      remaining <= LEN_ONE;
      fill      <= '0;
      pos_x     <= '0;
      pos_y     <= '0;
      buttons   <= '0;
      key_map   <= '0;
    end else begin
      mode      <= mode_next;
      remaining <= remaining_next;
      fill      <= fill_next;
      pos_x     <= pos_x_next;
      pos_y     <= pos_y_next;
      buttons   <= buttons_next;
      if (keys_clear) begin
        key_map <= '0;
      end else if (key_valid) begin
        key_map[key_index] <= key_down;
      end
    end
  end

  always_ff @(posedge clk) begin
    pkt <= pkt_next;
  end

  always_comb begin
    result.fault         = (mode_next == MODE_FAULT);
    result.key_valid     = key_valid;
    result.key_index     = key_index;
    result.key_down      = key_down;
    result.key_changed   = key_changed;
    result.mouse_valid   = mouse_valid;
    result.mouse_buttons = buttons_next;
    result.mouse_x       = $signed(pos_x_next);
    result.mouse_y       = $signed(pos_y_next);
  end

endmodule

`default_nettype wire

// ===== sv/keyboard_mouse_packet_parser_top.sv =====
// An input transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle while out_stall is low; every accepted byte yields exactly one result.
// The input register and the result register each take a new transaction while the
// other side stalls, so a stalled output backs up at most one item before in_stall rises.
// Reset (rst, synchronous, active high): both stages empty, key mode, mouse state zero,
// all keys released, parser_enable set.
`default_nettype none

module keyboard_mouse_packet_parser_top (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration: parser_enable
  input  wire logic              cfg_write,
  input  wire logic              cfg_wdata,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire kmpp_pkg::item_t   in_data,
  // output channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output kmpp_pkg::result_t      out_data
);
  import kmpp_pkg::*;

  logic      parser_enable;
  logic      in_q_valid;
  item_t     in_q;
  logic      advance;
  result_t   result;

  // An item moves to the result register when that register is empty or being drained.
  assign advance  = in_q_valid && (!out_valid || !out_stall);
  // Hold off the sender only while the input register is full and cannot move on.
  assign in_stall = in_q_valid && !advance;

  // Configuration: written only while the block is idle; the user must keep to this, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      parser_enable <= 1'b1;
    end else if (cfg_write) begin
      parser_enable <= cfg_wdata;
    end
  end

  // Input register: refill whenever it is empty or advancing this cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  // Parser state updates, while parser_enable is set, in the same cycle the item advances.
  kmpp_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .parser_enable (parser_enable),
    .item          (in_q),
    .result        (result)
  );

  // Result register: load on advance, drop once the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

// ===== sv/kmpp_checker.sv =====
// Port-level checks for the keyboard/mouse packet parser, bound to the top level.
// Depends on kmpp_pkg and keyboard_mouse_packet_parser_top_macros.svh.
`default_nettype none
`include "keyboard_mouse_packet_parser_top_macros.svh"

module kmpp_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire kmpp_pkg::result_t out_data
);
  import kmpp_pkg::*;

  `KMPP_ASSERT_RST(a_empty_after_reset, rst |=> !out_valid, "result present after reset")
  `KMPP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")
  `KMPP_ASSERT(a_key_fields_clear, out_valid && !out_data.key_valid |-> out_data.key_index == 7'd0 && !out_data.key_down && !out_data.key_changed, "key fields set without key event")
  `KMPP_ASSERT(a_one_event_kind, out_valid |-> !(out_data.key_valid && out_data.mouse_valid), "key and mouse event in one result")

endmodule

bind keyboard_mouse_packet_parser_top kmpp_checker u_kmpp_checker (.*);

`default_nettype wire
